FILE: design/orlb_pkg.sv
// ----------------------------------------------------------------------------
// orlb_pkg
// Shared constants, codes, types and helpers for the overwrite ring log buffer.
// ----------------------------------------------------------------------------
package orlb_pkg;

    localparam int RING_DEPTH  = 1024;
    localparam int SLOT_W      = $clog2(RING_DEPTH);
    localparam int SIZE_W      = $clog2(RING_DEPTH + 1);
    localparam int POS_W       = 48;
    localparam int DATA_W      = 8;
    localparam int CFG_SIZE_W  = 11;
    localparam int SIZE_RESET  = 1024;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int CMP_W       = (CFG_SIZE_W > SIZE_W) ? CFG_SIZE_W : SIZE_W;

    typedef enum logic [0:0] {
        OP_APPEND = 1'b0,
        OP_READ   = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NO_DATA = 2'd1,
        ST_DROPPED = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        REG_RING_SIZE = 1'b0,
        REG_NONE      = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic              wr;
        logic [SIZE_W-1:0] size;
    } cfg_t;

    typedef struct packed {
        status_t          status;
        logic [POS_W-1:0] used_position;
        logic             readable;
        logic [POS_W-1:0] oldest_position;
        logic [POS_W-1:0] end_position;
    } res_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_SIZE_W-1:0] v);
        logic [CMP_W-1:0] ve;
        ve = CMP_W'(v);
        if (ve < CMP_W'(2))
            return SIZE_W'(2);
        else if (ve > CMP_W'(RING_DEPTH))
            return SIZE_W'(RING_DEPTH);
        else
            return SIZE_W'(ve);
    endfunction

endpackage

FILE: design/orlb_if.sv
// ----------------------------------------------------------------------------
// orlb_if
// Valid/ready channels for log requests and log results.
// ----------------------------------------------------------------------------
interface orlb_in_if import orlb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             op;
    logic [7:0]       data_byte;
    logic             message_start;
    logic [POS_W-1:0] read_position;

    modport source (output valid, op, data_byte, message_start, read_position, input ready);
    modport sink   (input valid, op, data_byte, message_start, read_position, output ready);
endinterface

interface orlb_out_if import orlb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [7:0]       read_data;
    logic [POS_W-1:0] used_position;
    logic             readable;
    logic [POS_W-1:0] oldest_position;
    logic [POS_W-1:0] end_position;

    modport source (output valid, status, read_data, used_position, readable,
                    oldest_position, end_position, input ready);
    modport sink   (input valid, status, read_data, used_position, readable,
                    oldest_position, end_position, output ready);
endinterface

FILE: design/orlb_apb.sv
// ----------------------------------------------------------------------------
// orlb_apb
// APB register port holding the ring size; flags each size write.
// ----------------------------------------------------------------------------
module orlb_apb import orlb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] size_next;
    reg_idx_t          idx;
    logic              wr_size;

    assign idx     = reg_idx_t'(paddr[2]);
    assign pready  = 1'b1;
    assign wr_size = psel && penable && pwrite && (idx == REG_RING_SIZE);

    always_comb
    begin
        size_next = size_reg;
        if (wr_size)
            size_next = clamp_size(pwdata[CFG_SIZE_W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= clamp_size(CFG_SIZE_W'(SIZE_RESET));
        else
            size_reg <= size_next;
    end

    always_comb
    begin
        unique case (idx)
            REG_RING_SIZE: prdata = APB_DW'(size_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.wr   = wr_size;
    assign cfg.size = size_reg;

endmodule

FILE: design/orlb_engine.sv
// ----------------------------------------------------------------------------
// orlb_engine
// Input register, ring pointers, byte store and single-pass append/read logic.
// ----------------------------------------------------------------------------
module orlb_engine import orlb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    orlb_in_if.sink           log_in,
    input  logic              res_ready,
    output logic              res_fire,
    output res_t              res,
    output logic [DATA_W-1:0] rdata
);

    logic              s1_valid_reg, s1_valid_next;
    logic              s1_op_reg;
    logic [DATA_W-1:0] s1_byte_reg;
    logic              s1_start_reg;
    logic [POS_W-1:0]  s1_pos_reg;

    logic [SLOT_W-1:0] wslot_reg, wslot_next;
    logic [SLOT_W-1:0] oslot_reg, oslot_next;
    logic [SLOT_W-1:0] held_reg, held_next;
    logic [SLOT_W-1:0] taken_reg, taken_next;
    logic [POS_W-1:0]  opos_reg, opos_next;
    logic [POS_W-1:0]  end_reg, end_next;

    logic [DATA_W-1:0] ring_mem [RING_DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    logic              in_fire;
    logic              is_append;
    logic [SLOT_W-1:0] size_m1;
    logic [SLOT_W-1:0] taken;
    logic              drop;
    logic              full;
    logic              do_append;
    logic [SIZE_W-1:0] w_inc, o_inc;
    logic [POS_W-1:0]  used;
    logic              no_data;
    logic [SLOT_W-1:0] offset;
    logic [SLOT_W:0]   slot_sum;
    logic [SLOT_W:0]   size_x;
    logic [SLOT_W-1:0] rslot;

    assign res_fire     = s1_valid_reg && res_ready;
    assign log_in.ready = !s1_valid_reg || res_ready;
    assign in_fire      = log_in.valid && log_in.ready;
    assign is_append    = (op_t'(s1_op_reg) == OP_APPEND);

    always_comb
    begin
        size_m1   = SLOT_W'(cfg.size - SIZE_W'(1));
        taken     = s1_start_reg ? '0 : taken_reg;
        drop      = (taken >= size_m1) || (end_reg == {POS_W{1'b1}});
        full      = (held_reg >= size_m1);
        do_append = res_fire && is_append && !drop;

        w_inc = SIZE_W'(wslot_reg) + SIZE_W'(1);
        o_inc = SIZE_W'(oslot_reg) + SIZE_W'(1);

        used     = (s1_pos_reg < opos_reg) ? opos_reg : s1_pos_reg;
        no_data  = (used >= end_reg);
        offset   = used[SLOT_W-1:0] - opos_reg[SLOT_W-1:0];
        size_x   = (SLOT_W+1)'(cfg.size);
        slot_sum = {1'b0, oslot_reg} + {1'b0, offset};
        rslot    = (slot_sum >= size_x) ? SLOT_W'(slot_sum - size_x) : SLOT_W'(slot_sum);

        wslot_next = wslot_reg;
        oslot_next = oslot_reg;
        held_next  = held_reg;
        taken_next = taken_reg;
        opos_next  = opos_reg;
        end_next   = end_reg;

        if (do_append)
        begin
            wslot_next = (w_inc == cfg.size) ? '0 : SLOT_W'(w_inc);
            taken_next = taken + SLOT_W'(1);
            end_next   = end_reg + POS_W'(1);
            if (full)
            begin
                oslot_next = (o_inc == cfg.size) ? '0 : SLOT_W'(o_inc);
                opos_next  = opos_reg + POS_W'(1);
            end
            else
                held_next = held_reg + SLOT_W'(1);
        end

        if (cfg.wr)
        begin
            wslot_next = '0;
            oslot_next = '0;
            held_next  = '0;
            taken_next = '0;
            opos_next  = end_reg;
        end

        res.oldest_position = opos_next;
        res.end_position    = end_next;
        if (is_append)
        begin
            res.status        = drop ? ST_DROPPED : ST_DONE;
            res.used_position = '0;
            res.readable      = 1'b0;
        end
        else
        begin
            res.status        = no_data ? ST_NO_DATA : ST_DONE;
            res.used_position = used;
            res.readable      = !no_data;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (res_fire)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            wslot_reg    <= '0;
            oslot_reg    <= '0;
            held_reg     <= '0;
            taken_reg    <= '0;
            opos_reg     <= '0;
            end_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            wslot_reg    <= wslot_next;
            oslot_reg    <= oslot_next;
            held_reg     <= held_next;
            taken_reg    <= taken_next;
            opos_reg     <= opos_next;
            end_reg      <= end_next;
        end
    end

    // hold the transfer payload until the compute stage consumes it
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg    <= log_in.op;
            s1_byte_reg  <= log_in.data_byte;
            s1_start_reg <= log_in.message_start;
            s1_pos_reg   <= log_in.read_position;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_append)
            ring_mem[wslot_reg] <= s1_byte_reg;
        if (res_fire)
            rdata_reg <= ring_mem[rslot];
    end

    assign rdata = rdata_reg;

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        SIZE_W'(held_reg) < cfg.size)
        else $error("held count reached ring size");

    a_end_track: assert property (@(posedge clk) disable iff (!rst_n)
        end_reg == opos_reg + POS_W'(held_reg))
        else $error("end position out of step with oldest position and count");

    a_cfg_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.wr |=> (held_reg == '0) && (wslot_reg == '0) && (opos_reg == $past(end_reg)))
        else $error("size write did not empty the ring");

    a_drop_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (res_fire && is_append && drop && !cfg.wr) |=> $stable(end_reg) && $stable(wslot_reg))
        else $error("dropped append changed the ring");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (SIZE_W'(wslot_reg) < cfg.size) && (SIZE_W'(oslot_reg) < cfg.size))
        else $error("slot pointer beyond ring size");

endmodule

FILE: design/overwrite_ring_log_buffer.sv
// Path: an accepted transfer passes through the input register, then the result
// register, which also captures the store read.
// Throughput: one item per cycle; the compute stage and the byte store
// take an append or a read every cycle, and either side may stall.
// Reset: pointers, counts and positions clear to zero, ring empty, size 1024;
// the byte store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// overwrite_ring_log_buffer
// Byte log ring that overwrites the oldest byte and tracks stream positions.
// ----------------------------------------------------------------------------
module overwrite_ring_log_buffer import orlb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    orlb_in_if.sink           log_in,
    orlb_out_if.source        log_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    cfg_t              cfg;
    res_t              res;
    res_t              res_reg;
    logic              res_fire;
    logic              res_ready;
    logic [DATA_W-1:0] rdata;
    logic              out_valid_reg, out_valid_next;

    orlb_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    orlb_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .log_in    (log_in),
        .res_ready (res_ready),
        .res_fire  (res_fire),
        .res       (res),
        .rdata     (rdata)
    );

    assign res_ready = !out_valid_reg || log_out.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_fire)
            out_valid_next = 1'b1;
        else if (log_out.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_fire)
            res_reg <= res;
    end

    assign log_out.valid           = out_valid_reg;
    assign log_out.status          = res_reg.status;
    assign log_out.read_data       = res_reg.readable ? rdata : '0;
    assign log_out.used_position   = res_reg.used_position;
    assign log_out.readable        = res_reg.readable;
    assign log_out.oldest_position = res_reg.oldest_position;
    assign log_out.end_position    = res_reg.end_position;

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the overwrite ring log buffer. Each accepted log
// request runs through a bench model of the ring, and every reply is compared
// with the oldest outstanding one. A directed table comes first. Random phases
// follow, each under its own ring size, with message sequences and
// window-biased reads. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb;
    import orlb_pkg::*;

    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        op_t              op;
        logic [7:0]       data_byte;
        logic             message_start;
        logic [POS_W-1:0] read_position;
    } log_req_t;

    typedef struct packed {
        status_t          status;
        logic [7:0]       read_data;
        logic [POS_W-1:0] used_position;
        logic             readable;
        logic [POS_W-1:0] oldest_position;
        logic [POS_W-1:0] end_position;
    } log_reply_t;

    typedef struct {
        bit          is_cfg;
        reg_idx_t    cfg_reg;
        logic [31:0] cfg_value;
        log_req_t    req;
        bit          typed;
        log_reply_t  reply;
    } dir_row_t;

    typedef struct {
        logic [31:0] size_word;
        int          items;
    } phase_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    orlb_in_if  log_in_ch();
    orlb_out_if log_out_ch();

    overwrite_ring_log_buffer uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .log_in  (log_in_ch),
        .log_out (log_out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [7:0]       ring_bytes [RING_DEPTH];
    int unsigned      wr_slot;
    int unsigned      old_slot;
    int unsigned      msg_taken;
    int unsigned      size_in_use;
    logic [POS_W-1:0] old_pos;

    log_reply_t outstanding_replies[$];
    int         bad_replies;
    int         idle_pct;
    bit         hold_request;
    int         msg_left;
    dir_row_t   rows[$];
    phase_t     phases[$];

    function automatic int unsigned fit_size(logic [CFG_SIZE_W-1:0] v);
        if (v < 2)
            return 2;
        if (v > RING_DEPTH)
            return RING_DEPTH;
        return 32'(v);
    endfunction

    function automatic int unsigned bytes_held();
        if (wr_slot >= old_slot)
            return wr_slot - old_slot;
        return size_in_use - old_slot + wr_slot;
    endfunction

    function automatic logic [POS_W-1:0] stream_end();
        return old_pos + POS_W'(bytes_held());
    endfunction

    function automatic void write_register(reg_idx_t idx, logic [31:0] value);
        if (idx != REG_RING_SIZE)
            return;
        old_pos = stream_end();
        size_in_use = fit_size(value[CFG_SIZE_W-1:0]);
        wr_slot = 0;
        old_slot = 0;
        msg_taken = 0;
    endfunction

    function automatic log_reply_t apply_log_request(log_req_t q);
        log_reply_t       r;
        int unsigned      taken;
        int unsigned      slot;
        logic [POS_W-1:0] last;
        r = '0;
        r.status = ST_DONE;
        if (q.op == OP_APPEND)
        begin
            taken = q.message_start ? 0 : msg_taken;
            if (taken >= size_in_use - 1)
                r.status = ST_DROPPED;
            else if (stream_end() == POS_MAX)
                r.status = ST_DROPPED;
            else
            begin
                if (bytes_held() >= size_in_use - 1)
                begin
                    old_slot = (old_slot + 1) % size_in_use;
                    old_pos = old_pos + 1'b1;
                end
                ring_bytes[wr_slot] = q.data_byte;
                wr_slot = (wr_slot + 1) % size_in_use;
                msg_taken = taken + 1;
            end
        end
        else
        begin
            last = stream_end();
            r.used_position = (q.read_position < old_pos) ? old_pos : q.read_position;
            if (r.used_position >= last)
                r.status = ST_NO_DATA;
            else
            begin
                slot = (old_slot + int'(r.used_position - old_pos)) % size_in_use;
                r.read_data = ring_bytes[slot];
                r.readable = 1'b1;
            end
        end
        r.oldest_position = old_pos;
        r.end_position = stream_end();
        return r;
    endfunction

    function automatic log_req_t next_request();
        log_req_t         q;
        logic [POS_W-1:0] lo;
        q.data_byte = 8'($urandom);
        q.message_start = 1'($urandom);
        q.read_position = '0;
        if ($urandom_range(99) < 62)
        begin
            q.op = OP_APPEND;
            if (msg_left == 0)
            begin
                msg_left = $urandom_range(($urandom_range(3) == 0) ? size_in_use + 3 : 4, 1);
                q.message_start = 1'b1;
            end
            else
                q.message_start = ($urandom_range(19) == 0);
            msg_left--;
        end
        else
        begin
            q.op = OP_READ;
            case ($urandom_range(9))
                0: q.read_position = POS_W'({$urandom, $urandom});
                1: q.read_position = $urandom_range(1) ? POS_MAX : '0;
                default:
                begin
                    lo = (old_pos > 3) ? old_pos - 3 : '0;
                    q.read_position = lo + POS_W'($urandom_range(int'(stream_end() - lo) + 3));
                end
            endcase
        end
        return q;
    endfunction

    function automatic string reply_text(log_reply_t r);
        return $sformatf("status=%0d data=%02h used=%0d readable=%0d oldest=%0d end=%0d",
                         r.status, r.read_data, r.used_position, r.readable,
                         r.oldest_position, r.end_position);
    endfunction

    function automatic void note_bad(string what, log_reply_t want, log_reply_t got);
        bad_replies++;
        if (bad_replies <= 10)
            $display("%s\n  expected %s\n  actual   %s", what, reply_text(want), reply_text(got));
    endfunction

    function automatic dir_row_t plain_row(op_t op, logic [7:0] data, logic start,
                                           logic [POS_W-1:0] pos);
        dir_row_t row;
        row.is_cfg = 1'b0;
        row.cfg_reg = REG_RING_SIZE;
        row.cfg_value = '0;
        row.req = '{op, data, start, pos};
        row.typed = 1'b0;
        row.reply = '0;
        return row;
    endfunction

    function automatic dir_row_t typed_row(op_t op, logic [7:0] data, logic start,
                                           logic [POS_W-1:0] pos, status_t st,
                                           logic [7:0] rd, logic [POS_W-1:0] used,
                                           logic rdable, logic [POS_W-1:0] oldest,
                                           logic [POS_W-1:0] last);
        dir_row_t row;
        row = plain_row(op, data, start, pos);
        row.typed = 1'b1;
        row.reply = '{st, rd, used, rdable, oldest, last};
        return row;
    endfunction

    function automatic dir_row_t cfg_row(reg_idx_t idx, logic [31:0] value);
        dir_row_t row;
        row = plain_row(OP_READ, '0, 1'b0, '0);
        row.is_cfg = 1'b1;
        row.cfg_reg = idx;
        row.cfg_value = value;
        return row;
    endfunction

    task automatic push_item(input log_req_t q, input bit typed, input log_reply_t fixed);
        log_reply_t r;
        while ($urandom_range(99) < idle_pct)
        begin
            log_in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        log_in_ch.valid <= 1'b1;
        log_in_ch.op <= q.op;
        log_in_ch.data_byte <= q.data_byte;
        log_in_ch.message_start <= q.message_start;
        log_in_ch.read_position <= q.read_position;
        @(posedge clk);
        while (!log_in_ch.ready)
            @(posedge clk);
        r = apply_log_request(q);
        outstanding_replies.push_back(typed ? fixed : r);
    endtask

    task automatic wait_idle();
        log_in_ch.valid <= 1'b0;
        while (outstanding_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'({idx, 2'b00});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        write_register(idx, value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // reply side: random stalls, one long hold-off on request
    initial
    begin : reply_sink
        log_reply_t got;
        log_reply_t want;
        int         hold_left;
        hold_left = 0;
        log_out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (log_out_ch.valid && log_out_ch.ready)
            begin
                got = {log_out_ch.status, log_out_ch.read_data, log_out_ch.used_position,
                       log_out_ch.readable, log_out_ch.oldest_position,
                       log_out_ch.end_position};
                if (outstanding_replies.size() == 0)
                    note_bad("reply with no request outstanding", '0, got);
                else
                begin
                    want = outstanding_replies.pop_front();
                    if (got !== want)
                        note_bad("reply mismatch", want, got);
                end
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                log_out_ch.ready <= 1'b0;
            end
            else
                log_out_ch.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    initial
    begin
        bad_replies = 0;
        idle_pct = 18;
        hold_request = 1'b0;
        msg_left = 0;
        wr_slot = 0;
        old_slot = 0;
        msg_taken = 0;
        old_pos = '0;
        size_in_use = fit_size(CFG_SIZE_W'(SIZE_RESET));

        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        log_in_ch.valid <= 1'b0;
        log_in_ch.op <= OP_APPEND;
        log_in_ch.data_byte <= '0;
        log_in_ch.message_start <= 1'b0;
        log_in_ch.read_position <= '0;

        // empty ring after reset, then a short message and reads around it
        rows.push_back(typed_row(OP_READ, 8'h00, 1'b0, '0, ST_NO_DATA, 8'h00, '0, 1'b0,
                                 '0, '0));
        rows.push_back(typed_row(OP_READ, 8'hFF, 1'b1, POS_MAX, ST_NO_DATA, 8'h00, POS_MAX,
                                 1'b0, '0, '0));
        rows.push_back(typed_row(OP_APPEND, 8'h00, 1'b1, '0, ST_DONE, 8'h00, '0, 1'b0,
                                 '0, 48'd1));
        rows.push_back(typed_row(OP_APPEND, 8'hFF, 1'b0, POS_MAX, ST_DONE, 8'h00, '0, 1'b0,
                                 '0, 48'd2));
        rows.push_back(typed_row(OP_APPEND, 8'hA5, 1'b0, '0, ST_DONE, 8'h00, '0, 1'b0,
                                 '0, 48'd3));
        rows.push_back(typed_row(OP_READ, 8'h00, 1'b0, 48'd0, ST_DONE, 8'h00, 48'd0, 1'b1,
                                 '0, 48'd3));
        rows.push_back(typed_row(OP_READ, 8'h00, 1'b0, 48'd1, ST_DONE, 8'hFF, 48'd1, 1'b1,
                                 '0, 48'd3));
        rows.push_back(typed_row(OP_READ, 8'h00, 1'b0, 48'd2, ST_DONE, 8'hA5, 48'd2, 1'b1,
                                 '0, 48'd3));
        rows.push_back(typed_row(OP_READ, 8'h00, 1'b0, 48'd3, ST_NO_DATA, 8'h00, 48'd3,
                                 1'b0, '0, 48'd3));
        // unknown register index leaves the ring alone
        rows.push_back(cfg_row(REG_NONE, 32'd2));
        rows.push_back(plain_row(OP_READ, 8'h00, 1'b0, 48'd1));
        // size below range acts as two: read clamps up, long message drops, ring wraps
        rows.push_back(cfg_row(REG_RING_SIZE, 32'd0));
        rows.push_back(typed_row(OP_READ, 8'h00, 1'b0, 48'd0, ST_NO_DATA, 8'h00, 48'd3,
                                 1'b0, 48'd3, 48'd3));
        rows.push_back(typed_row(OP_APPEND, 8'h5A, 1'b1, '0, ST_DONE, 8'h00, '0, 1'b0,
                                 48'd3, 48'd4));
        rows.push_back(typed_row(OP_APPEND, 8'h11, 1'b0, '0, ST_DROPPED, 8'h00, '0, 1'b0,
                                 48'd3, 48'd4));
        rows.push_back(typed_row(OP_APPEND, 8'h22, 1'b1, '0, ST_DONE, 8'h00, '0, 1'b0,
                                 48'd4, 48'd5));
        rows.push_back(typed_row(OP_READ, 8'h00, 1'b0, 48'd3, ST_DONE, 8'h22, 48'd4, 1'b1,
                                 48'd4, 48'd5));
        // upper data bits are ignored: this selects three slots
        rows.push_back(cfg_row(REG_RING_SIZE, 32'hFFFF_F803));
        rows.push_back(plain_row(OP_APPEND, 8'h80, 1'b1, '0));
        rows.push_back(plain_row(OP_APPEND, 8'h01, 1'b0, '0));
        rows.push_back(plain_row(OP_APPEND, 8'h7E, 1'b0, '0));
        rows.push_back(plain_row(OP_APPEND, 8'h7F, 1'b1, '0));
        rows.push_back(plain_row(OP_READ, 8'h00, 1'b0, POS_MAX));
        rows.push_back(plain_row(OP_READ, 8'h00, 1'b0, '0));
        rows.push_back(plain_row(OP_READ, 8'h00, 1'b0, 48'd6));

        phases.push_back('{32'd2, 150});
        phases.push_back('{32'd5, 100});
        phases.push_back('{32'd16, 200});
        phases.push_back('{32'd200, 350});
        phases.push_back('{32'd1024, 80});
        phases.push_back('{32'd2047, 60});
        phases.push_back('{32'd1, 80});
        phases.push_back('{32'hABCD_0009, 120});
        phases.push_back('{32'd3, 150});
        phases.push_back('{32'd64, 150});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
            begin
                wait_idle();
                apb_write(rows[i].cfg_reg, rows[i].cfg_value);
            end
            else
                push_item(rows[i].req, rows[i].typed, rows[i].reply);
        end

        foreach (phases[p])
        begin
            wait_idle();
            if ($urandom_range(2) == 0)
                apb_write(REG_NONE, $urandom);
            apb_write(REG_RING_SIZE, phases[p].size_word);
            msg_left = 0;
            idle_pct = (p == 3) ? 0 : 18;
            for (int n = 0; n < phases[p].items; n++)
            begin
                if (p == 6 && n == 20)
                    hold_request = 1'b1;
                if (p == 7 && n == 60)
                    wait_idle();
                push_item(next_request(), 1'b0, '0);
            end
        end

        wait_idle();
        if (bad_replies == 0 && outstanding_replies.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

FILE: filelist.f
design/orlb_pkg.sv
design/orlb_if.sv
design/orlb_apb.sv
design/orlb_engine.sv
design/overwrite_ring_log_buffer.sv
dv/tb.sv
